// ===== design/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types, constants and helpers for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int NUM_PAGES = 256;
  localparam int PW        = $clog2(NUM_PAGES);   // page index width
  localparam int CW        = PW + 1;              // count / length width

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_EXCEEDS = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] page_base;
    logic [8:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] page_start;
    logic [8:0] pages_avail;
  } out_item_t;

  typedef struct packed {
    logic [PW-1:0] start;
    logic [CW-1:0] len;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Operands and flags of the shared merge/compare unit.
  typedef struct packed {
    logic [PW-1:0] a_start;
    logic [CW-1:0] a_len;
    logic [PW-1:0] b_start;
    logic [CW-1:0] b_len;
    logic [CW-1:0] need;
  } alu_in_t;

  typedef struct packed {
    logic [PW-1:0] a_end;
    logic          a_meets_b;
    logic          b_meets_a;
    logic          b_fits;
  } alu_out_t;

  // Page index plus an offset of at most NUM_PAGES, modulo NUM_PAGES.
  function automatic logic [PW-1:0] wrap_sum(input logic [PW-1:0] s,
                                             input logic [CW-1:0] l);
    logic [CW:0] t;
    t = {2'b00, s} + {1'b0, l};
    if (t >= (CW+1)'(NUM_PAGES)) t = t - (CW+1)'(NUM_PAGES);
    return t[PW-1:0];
  endfunction

endpackage

// ===== design/ffpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ffpa_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_alu
// Shared block arithmetic: wrapped end page, adjacency tests and fit test.
// ----------------------------------------------------------------------------
module ffpa_alu (
  input  ffpa_pkg::alu_in_t  ai,
  output ffpa_pkg::alu_out_t ao
);
  import ffpa_pkg::*;

  logic [PW-1:0] b_end;

  always_comb begin
    ao.a_end     = wrap_sum(ai.a_start, ai.a_len);
    b_end        = wrap_sum(ai.b_start, ai.b_len);
    ao.a_meets_b = (ao.a_end == ai.b_start);
    ao.b_meets_a = (b_end == ai.a_start);
    ao.b_fits    = (ai.b_len >= ai.need);
  end

endmodule

// ===== design/first_fit_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Free-block table in a circular RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
// Add writes one single-page entry per page; alloc reads entries up to the
// first fit, then shifts the later ones down; free reads every entry; rejected
// items skip the table. The table RAM's single read port sets the walk length.
// One item is in work at a time; a new one is taken in the cycle after the
// result is handed to the output register. Reset empties the table and zeroes
// the free total.
module first_fit_page_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffpa_pkg::out_item_t out_data
);
  import ffpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADD, S_FIND_RD, S_FIND_USE, S_REM_RD, S_REM_USE,
    S_FREE_RD, S_FREE_USE, S_FREE_END, S_DONE
  } state_t;

  state_t        state;
  logic [1:0]    op;
  logic [PW-1:0] base;
  logic [CW-1:0] need;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;
  logic [CW-1:0] kept;
  logic [PW-1:0] m_start;
  logic [CW-1:0] m_len;
  entry_t        hit;
  status_t       res_status;
  logic [PW-1:0] res_start;

  logic          we;
  logic [PW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  alu_in_t       ai;
  alu_out_t      ao;
  logic [PW-1:0] head_dec;
  logic [CW:0]   total_plus;

  ffpa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ffpa_alu u_alu (.ai(ai), .ao(ao));

  assign in_stall   = (state != S_IDLE);
  assign head_dec   = (head == '0) ? PW'(NUM_PAGES - 1) : head - PW'(1);
  assign total_plus = {1'b0, total} + {1'b0, need};

  always_comb begin
    ai.a_start = m_start;
    ai.a_len   = m_len;
    ai.b_start = rdata.start;
    ai.b_len   = rdata.len;
    ai.need    = need;
    case (state)
      S_ADD: begin
        ai.a_start = base;
        ai.a_len   = idx;
      end
      S_REM_RD: begin
        ai.a_start = hit.start;
        ai.a_len   = need;
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = wrap_sum(head, count);
    wdata = {ao.a_end, CW'(1)};
    raddr = wrap_sum(head, idx);
    case (state)
      S_ADD: we = 1'b1;
      S_REM_RD: begin
        raddr = wrap_sum(head, idx + CW'(1));
        if (idx + CW'(1) >= count && hit.len > need) begin
          we    = 1'b1;
          waddr = head_dec;
          wdata = {ao.a_end, hit.len - need};
        end
      end
      S_REM_USE: begin
        we    = 1'b1;
        waddr = wrap_sum(head, idx);
        wdata = rdata;
      end
      S_FREE_USE: begin
        we    = !ao.a_meets_b && !ao.b_meets_a;
        waddr = wrap_sum(head, kept);
        wdata = rdata;
      end
      S_FREE_END: begin
        we    = 1'b1;
        waddr = head_dec;
        wdata = {m_start, m_len};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_data.op;
            base      <= PW'(in_data.page_base);
            need      <= CW'(in_data.page_count);
            res_start <= '0;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx        <= '0;
          kept       <= '0;
          m_start    <= base;
          m_len      <= need;
          res_status <= ST_OK;
          state      <= S_DONE;
          if (op == OP_NONE) begin
            // An unknown operation leaves everything as it is.
          end else if (need == '0) begin
            res_status <= ST_ZERO;
          end else if (op == OP_ADD || op == OP_FREE) begin
            if (total_plus > (CW+1)'(NUM_PAGES)) res_status <= ST_FULL;
            else state <= (op == OP_ADD) ? S_ADD : S_FREE_RD;
          end else if (op == OP_ALLOC) begin
            if (need > total) res_status <= ST_EXCEEDS;
            else state <= S_FIND_RD;
          end
        end
        S_ADD: begin
          count <= count + CW'(1);
          idx   <= idx + CW'(1);
          if (idx + CW'(1) == need) begin
            total <= total_plus[CW-1:0];
            state <= S_DONE;
          end
        end
        S_FIND_RD: begin
          if (idx == count) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            state <= S_FIND_USE;
          end
        end
        S_FIND_USE: begin
          if (ao.b_fits) begin
            hit   <= rdata;
            state <= S_REM_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end
        end
        S_REM_RD: begin
          if (idx + CW'(1) >= count) begin
            // Hit entry is squeezed out; a remainder goes back at the head.
            if (hit.len > need) head <= head_dec;
            else count <= count - CW'(1);
            total     <= total - need;
            res_start <= hit.start;
            state     <= S_DONE;
          end else begin
            state <= S_REM_USE;
          end
        end
        S_REM_USE: begin
          idx   <= idx + CW'(1);
          state <= S_REM_RD;
        end
        S_FREE_RD: begin
          state <= (idx == count) ? S_FREE_END : S_FREE_USE;
        end
        S_FREE_USE: begin
          if (ao.a_meets_b) begin
            m_len <= m_len + rdata.len;
          end else if (ao.b_meets_a) begin
            m_start <= rdata.start;
            m_len   <= m_len + rdata.len;
          end else begin
            kept <= kept + CW'(1);
          end
          idx   <= idx + CW'(1);
          state <= S_FREE_RD;
        end
        S_FREE_END: begin
          head  <= head_dec;
          count <= kept + CW'(1);
          total <= total_plus[CW-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.status      <= res_status;
            out_data.page_start  <= 8'(res_start);
            out_data.pages_avail <= 9'(total);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Every stored block holds at least one page; an add brings the total up
  // only on its last cycle.
  a_count_le_total: assert property (@(posedge clk) disable iff (rst)
    state != S_ADD |-> count <= total) else $error("block count exceeds free total");

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(NUM_PAGES)) else $error("free total exceeds page count");

  // A successful alloc reports a page only when status is ok.
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.page_start == '0)
    else $error("page start set on failed result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_DONE |-> !we)
    else $error("table write outside an operation");
`endif

endmodule

// ===== tb/sv/first_fit_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_tb
// Drives add, alloc and free requests into the page allocator and predicts
// each response with an in-bench copy of the free-block list. Responses are
// compared field by field in order, under random idling on both sides and
// with long output back-pressure.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_tb;
  import ffpa_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  first_fit_page_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Predicted free list, head at index 0.
  logic [7:0] blk_start [NUM_PAGES];
  logic [8:0] blk_len [NUM_PAGES];
  int         blk_count = 0;
  int         pages_free = 0;

  out_item_t  pending_results [$];
  logic [16:0] held_blocks [$];   // {start, len} of successful allocations
  int         errs = 0;
  int         cyc = 0;
  int         snd_idle = 0;
  int         rcv_idle = 0;
  bit         hold_request = 0;
  int         hold_cnt = 0;

  // Handshake state sampled mid-cycle, where every signal has settled.
  bit         in_taken, out_taken;
  out_item_t  out_seen;

  always @(negedge clk) begin
    in_taken  = in_valid && !in_stall;
    out_taken = out_valid && !out_stall;
    out_seen  = out_data;
  end

  function automatic void push_head(int upto, logic [7:0] s, logic [8:0] l);
    for (int j = upto; j > 0; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_len[j]   = blk_len[j-1];
    end
    blk_start[0] = s;
    blk_len[0]   = l;
  endfunction

  function automatic out_item_t alloc_predict(in_item_t it);
    out_item_t r;
    int n, i, kept;
    int ms, ml;
    n = it.page_count;
    r = '0;
    r.status = ST_OK;
    if (it.op != OP_NONE && n == 0) begin
      r.status = ST_ZERO;
    end else if (it.op == OP_ADD) begin
      if (pages_free + n > NUM_PAGES) begin
        r.status = ST_FULL;
      end else begin
        for (int k = 0; k < n; k++) begin
          blk_start[blk_count] = (it.page_base + k) % NUM_PAGES;
          blk_len[blk_count]   = 1;
          blk_count++;
        end
        pages_free += n;
      end
    end else if (it.op == OP_ALLOC) begin
      if (n > pages_free) begin
        r.status = ST_EXCEEDS;
      end else begin
        for (i = 0; i < blk_count; i++)
          if (blk_len[i] >= n) break;
        if (i >= blk_count) begin
          r.status = ST_NOFIT;
        end else begin
          r.page_start = blk_start[i];
          if (blk_len[i] > n) begin
            ms = (blk_start[i] + n) % NUM_PAGES;
            ml = blk_len[i] - n;
            push_head(i, ms, ml);
          end else begin
            for (int j = i; j < blk_count - 1; j++) begin
              blk_start[j] = blk_start[j+1];
              blk_len[j]   = blk_len[j+1];
            end
            blk_count--;
          end
          pages_free -= n;
        end
      end
    end else if (it.op == OP_FREE) begin
      if (pages_free + n > NUM_PAGES) begin
        r.status = ST_FULL;
      end else begin
        ms = it.page_base;
        ml = n;
        kept = 0;
        // One pass: absorb the following and the preceding neighbor.
        for (int j = 0; j < blk_count; j++) begin
          if ((ms + ml) % NUM_PAGES == blk_start[j]) begin
            ml += blk_len[j];
          end else if ((blk_start[j] + blk_len[j]) % NUM_PAGES == ms) begin
            ms = blk_start[j];
            ml += blk_len[j];
          end else begin
            blk_start[kept] = blk_start[j];
            blk_len[kept]   = blk_len[j];
            kept++;
          end
        end
        blk_count = kept;
        push_head(blk_count, ms, ml);
        blk_count++;
        pages_free += n;
      end
    end
    r.pages_avail = pages_free;
    return r;
  endfunction

  // Offers one request and returns at the edge where the transfer happens.
  task automatic send_req(logic [1:0] op, int base, int count);
    in_item_t it;
    out_item_t r;
    it.op = op;
    it.page_base = base;
    it.page_count = count;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_taken);
    r = alloc_predict(it);
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK)
      held_blocks.push_back({r.page_start, it.page_count});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk) begin
    out_item_t e;
    cyc++;
    if (cyc > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && out_taken) begin
      if (pending_results.size() == 0) begin
        $error("response with nothing expected: %p", out_seen);
        errs++;
      end else begin
        e = pending_results.pop_front();
        if (out_seen.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_seen.status);
          errs++;
        end
        if (out_seen.page_start !== e.page_start) begin
          $error("page_start: expected %0d, got %0d", e.page_start, out_seen.page_start);
          errs++;
        end
        if (out_seen.pages_avail !== e.pages_avail) begin
          $error("pages_avail: expected %0d, got %0d", e.pages_avail,
                 out_seen.pages_avail);
          errs++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(OP_NONE, 255, 511);     // unknown op with every field bit set
    send_req(OP_NONE, 3, 0);         // unknown op with a zero count
    send_req(OP_ALLOC, 0, 0);        // zero count on each op
    send_req(OP_ADD, 7, 0);
    send_req(OP_FREE, 7, 0);
    send_req(OP_ALLOC, 0, 1);        // empty table, exceeds total
    send_req(OP_ADD, 250, 10);       // region wraps past the last page
    send_req(OP_ALLOC, 0, 1);
    send_req(OP_ALLOC, 0, 2);        // only single pages, no fit
    send_req(OP_ALLOC, 0, 20);
    send_req(OP_FREE, 250, 1);       // merges with the page after it
    send_req(OP_ALLOC, 0, 2);        // remainder goes to the head
    send_req(OP_FREE, 0, 256);       // capacity exceeded
    send_req(OP_FREE, 255, 1);       // page inside a free block, so no merge
    send_req(OP_ADD, 10, 246);       // brings the free total to one short of every page
    send_req(OP_ADD, 5, 1);
    send_req(OP_FREE, 200, 1);
    send_req(OP_ALLOC, 0, 256);
    send_req(OP_ALLOC, 0, 9);
    send_req(OP_ALLOC, 0, 1);
    send_req(OP_ALLOC, 0, 255);
    drain();
  endtask

  task automatic test_random(int n_items);
    int pick, idx, c;
    logic [16:0] b;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Noise: any op and base, with a count from 0 to 256.
        c = ($urandom_range(3) == 0) ? $urandom_range(256) : $urandom_range(8);
        send_req($urandom_range(3), $urandom_range(255), c);
      end else if (pages_free < 48 && pick < 40) begin
        c = ($urandom_range(15) == 0) ? NUM_PAGES - pages_free : $urandom_range(1, 16);
        send_req(OP_ADD, $urandom_range(255), c);
      end else if (held_blocks.size() > 0 && pick < 65) begin
        idx = $urandom_range(held_blocks.size() - 1);
        b = held_blocks[idx];
        held_blocks.delete(idx);
        send_req(OP_FREE, b[16:9], b[8:0]);
      end else begin
        c = ($urandom_range(19) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 6);
        send_req(OP_ALLOC, 0, c);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1;
    test_random(30);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle = 20;
    rcv_idle = 60;
    test_directed();
    test_random(300);
    drain();
    snd_idle = 60;
    rcv_idle = 20;
    test_random(300);
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    test_backpressure();
    test_random(270);
    drain();
    if (errs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
